FILE: rtl/lkv_pkg.sv
`default_nettype none

package lkv_pkg;

    // Field widths fixed by the item format
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Opcodes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [KEY_W-1:0] lookup_key;
        logic [VAL_W-1:0] write_value;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
        logic [VAL_W-1:0] evicted_value;
    } rsp_t;

    // Broadcast to every cell for the item being applied
    typedef struct packed {
        logic promote;   // key found: move it to the head
        logic insert;    // put miss: push a new entry at the head
        logic evict;     // insert drops the tail entry
    } cell_cmd_t;

    // Where a cell sits relative to the occupied part of the row
    typedef struct packed {
        logic valid;
        logic prev_valid;
        logic tail;
    } cell_pos_t;

    // Passed from the tail end of the row towards the head
    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] found_value;
        logic [KEY_W-1:0] tail_key;
        logic [VAL_W-1:0] tail_value;
    } chain_t;

endpackage

`default_nettype wire

FILE: rtl/lkv_cell.sv
`default_nettype none

// One recency slot. Cell 0 is the most recent entry.
module lkv_cell (
    input  wire logic                      clk,
    input  wire logic [lkv_pkg::KEY_W-1:0] lookup_key,
    input  wire lkv_pkg::cell_cmd_t        cmd,
    input  wire lkv_pkg::cell_pos_t        pos,
    input  wire logic [lkv_pkg::KEY_W-1:0] prev_key,
    input  wire logic [lkv_pkg::VAL_W-1:0] prev_value,
    output logic [lkv_pkg::KEY_W-1:0]      key,
    output logic [lkv_pkg::VAL_W-1:0]      value,
    input  wire lkv_pkg::chain_t           chain_in,
    output lkv_pkg::chain_t                chain_out
);

    logic [lkv_pkg::KEY_W-1:0] key_reg;
    logic [lkv_pkg::VAL_W-1:0] value_reg;
    logic                      match;
    logic                      shift_en;

    assign match = pos.valid && (key_reg == lookup_key);

    always_comb
    begin
        chain_out.found       = match | chain_in.found;
        chain_out.found_value = match ? value_reg : chain_in.found_value;
        chain_out.tail_key    = pos.tail ? key_reg : chain_in.tail_key;
        chain_out.tail_value  = pos.tail ? value_reg : chain_in.tail_value;
    end

    // Promote: every cell from the head down to the hit takes its neighbour.
    // Insert: the occupied cells move down; the tail falls off on eviction.
    always_comb
    begin
        if (cmd.promote)
            shift_en = chain_out.found;
        else if (cmd.insert)
            shift_en = pos.valid || (!cmd.evict && pos.prev_valid);
        else
            shift_en = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            key_reg   <= prev_key;
            value_reg <= prev_value;
        end
    end

    assign key   = key_reg;
    assign value = value_reg;

endmodule

`default_nettype wire

FILE: rtl/lru_key_value_cache_unit.sv
`default_nettype none

// Fully associative key/value cache with least-recently-used replacement.
// Entries live in a row of ENTRIES cells kept in recency order: cell 0 holds
// the most recent entry and the occupied cells are always 0..count-1. Each
// get or put is taken into an input register; then every cell compares its
// key against it, the match and the tail entry ripple along the row to the
// head, and the row shifts by one place where needed while the response is
// loaded into the output register. A new item is therefore processed every
// cycle when the output side keeps up; out_valid rises once the item has moved
// from the input register into the output register, which an output stall can
// delay. The rate is set by the compare and hand-over chain through the cells,
// which is combinational between those two registers.
// There is no clearing pass after reset: the cache is empty immediately.
// The capacity register (reset 16) may be written at any time the block is
// idle; 0 behaves as 1 and values above ENTRIES behave as ENTRIES. Lowering
// it below the current fill makes each later insert evict one entry.
module lru_key_value_cache_unit #(
    parameter int ENTRIES = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // request channel
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire lkv_pkg::req_t             in_data,
    // response channel
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output lkv_pkg::rsp_t                  out_data,
    // capacity register write
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [lkv_pkg::CAP_W-1:0] cfg_data
);

    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > lkv_pkg::CAP_W) ? CW : lkv_pkg::CAP_W;

    // Input stage
    logic          req_valid_reg, req_valid_next;
    lkv_pkg::req_t req_reg, req_next;
    // Output stage
    logic          rsp_valid_reg, rsp_valid_next;
    lkv_pkg::rsp_t rsp_reg, rsp_next;
    // State
    logic [lkv_pkg::CAP_W-1:0] capacity_reg, capacity_next;
    logic [CW-1:0]             count_reg, count_next;

    logic              in_xfer;
    logic              fire;
    logic [CMPW-1:0]   cap_eff;
    logic              full;
    logic              is_put;
    lkv_pkg::cell_cmd_t cmd;

    logic [ENTRIES-1:0]     valid_vec;
    lkv_pkg::cell_pos_t     pos  [ENTRIES];
    lkv_pkg::chain_t        chain[ENTRIES+1];
    logic [lkv_pkg::KEY_W-1:0] cell_key  [ENTRIES+1];
    logic [lkv_pkg::VAL_W-1:0] cell_value[ENTRIES+1];

    // Handshakes: the item in the input register is applied when the
    // output register is empty or being drained this cycle.
    assign fire      = req_valid_reg && (!rsp_valid_reg || !out_stall);
    assign in_stall  = req_valid_reg && !fire;
    assign in_xfer   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Effective capacity, clamped to 1..ENTRIES
    always_comb
    begin
        cap_eff = CMPW'(capacity_reg);
        if (capacity_reg == '0)
            cap_eff = CMPW'(1);
        else if (CMPW'(capacity_reg) > CMPW'(ENTRIES))
            cap_eff = CMPW'(ENTRIES);
    end

    assign full   = CMPW'(count_reg) >= cap_eff;
    assign is_put = (req_reg.opcode == lkv_pkg::OP_PUT);

    // Thermometer of occupied cells
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_pos
        assign valid_vec[i] = count_reg > CW'(i);
        always_comb
        begin
            pos[i].valid = valid_vec[i];
            if (i == 0)
                pos[i].prev_valid = 1'b1;
            else
                pos[i].prev_valid = valid_vec[(i == 0) ? 0 : i-1];
            if (i == ENTRIES-1)
                pos[i].tail = valid_vec[i];
            else
                pos[i].tail = valid_vec[i] && !valid_vec[(i == ENTRIES-1) ? i : i+1];
        end
    end

    always_comb
    begin
        cmd.promote = fire && chain[0].found;
        cmd.insert  = fire && !chain[0].found && is_put;
        cmd.evict   = full;
    end

    // Data entering the head cell
    assign cell_key[0]   = req_reg.lookup_key;
    assign cell_value[0] = is_put ? req_reg.write_value : chain[0].found_value;

    // Empty end of the chain
    assign chain[ENTRIES] = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lkv_cell u_cell (
            .clk        (clk),
            .lookup_key (req_reg.lookup_key),
            .cmd        (cmd),
            .pos        (pos[i]),
            .prev_key   (cell_key[i]),
            .prev_value (cell_value[i]),
            .key        (cell_key[i+1]),
            .value      (cell_value[i+1]),
            .chain_in   (chain[i+1]),
            .chain_out  (chain[i])
        );
    end

    // Response
    always_comb
    begin
        rsp_next.hit           = chain[0].found;
        rsp_next.read_value    = (chain[0].found && !is_put) ? chain[0].found_value : '0;
        rsp_next.evicted       = !chain[0].found && is_put && full;
        rsp_next.evicted_key   = rsp_next.evicted ? chain[0].tail_key : '0;
        rsp_next.evicted_value = rsp_next.evicted ? chain[0].tail_value : '0;
    end

    // Control next state
    always_comb
    begin
        req_next       = in_xfer ? in_data : req_reg;
        req_valid_next = in_xfer ? 1'b1 : (fire ? 1'b0 : req_valid_reg);

        if (fire)
            rsp_valid_next = 1'b1;
        else if (!out_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;

        count_next = count_reg;
        if (cmd.insert && !full)
            count_next = count_reg + CW'(1);

        capacity_next = (cfg_valid && cfg_ready) ? cfg_data : capacity_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
            capacity_reg  <= lkv_pkg::CAP_RESET;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            count_reg     <= count_next;
            capacity_reg  <= capacity_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        if (fire)
            rsp_reg <= rsp_next;
    end

    assign out_valid = rsp_valid_reg;
    assign out_data  = rsp_reg;

endmodule

`default_nettype wire

FILE: rtl/lkv_checker.sv
`default_nettype none

module lkv_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_stall,
    input wire lkv_pkg::req_t             in_data,
    input wire logic                      out_valid,
    input wire logic                      out_stall,
    input wire lkv_pkg::rsp_t             out_data
);

    // A hit never evicts
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.hit && out_data.evicted))
        else $error("hit and eviction reported together");

    // Eviction fields are zero when nothing was evicted
    a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.evicted) |->
            (out_data.evicted_key == '0 && out_data.evicted_value == '0))
        else $error("eviction fields set without eviction");

    // Read value only on a hit
    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.hit) |-> (out_data.read_value == '0))
        else $error("read value on a miss");

    // A held response stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled response changed");

    // A stalled request is held by the sender
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_stall) |=> (in_valid && $stable(in_data)))
        else $error("stalled request changed");

endmodule

bind lru_key_value_cache_unit lkv_checker u_lkv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

FILE: bench/tb_lru_key_value_cache_unit.sv
`timescale 1ns / 100ps

module tb_lru_key_value_cache_unit;

    localparam int ENTRIES    = 16;
    localparam int IDLE_LIMIT = 3000;   // cycles without any transfer before giving up
    localparam int POOL_SIZE  = 24;
    localparam int NUM_PHASES = 6;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    lkv_pkg::req_t             in_data   = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    lkv_pkg::rsp_t             out_data;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [lkv_pkg::CAP_W-1:0] cfg_data  = lkv_pkg::CAP_RESET;

    always #5 clk = ~clk;

    lru_key_value_cache_unit #(
        .ENTRIES(ENTRIES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the cache. Slot order is irrelevant to the outputs;
    // only keys, values and recency ranks matter (rank 0 = most recent).
    // ------------------------------------------------------------------
    logic [lkv_pkg::KEY_W-1:0] line_key   [ENTRIES];
    logic [lkv_pkg::VAL_W-1:0] line_value [ENTRIES];
    bit                        line_valid [ENTRIES];
    int unsigned               line_rank  [ENTRIES];
    int unsigned               line_count;
    logic [lkv_pkg::CAP_W-1:0] capacity_reg;

    lkv_pkg::req_t pending_reqs[$];    // items waiting for the driver
    lkv_pkg::rsp_t expected_rsps[$];   // responses owed by the block, oldest first

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int idle_cycles    = 0;

    logic [lkv_pkg::KEY_W-1:0] pool_keys[POOL_SIZE];

    // Move slot s to the head; valid entries that were more recent age by one.
    function automatic void make_most_recent(int s);
        int unsigned r;
        r = line_rank[s];
        for (int i = 0; i < ENTRIES; i++)
            if (line_valid[i] && i != s && line_rank[i] < r)
                line_rank[i]++;
        line_rank[s] = 0;
    endfunction

    // Apply one get/put to the shadow cache and return the response it owes.
    function automatic lkv_pkg::rsp_t lru_access(lkv_pkg::req_t r);
        lkv_pkg::rsp_t res;
        int unsigned   cap_eff;
        int            slot;
        bit            found;
        bit            have;
        res   = '0;
        slot  = 0;
        found = 1'b0;
        have  = 1'b0;
        // zero acts as one, anything above the row size as the row size
        cap_eff = (capacity_reg == 0) ? 1 : capacity_reg;
        if (cap_eff > ENTRIES)
            cap_eff = ENTRIES;

        for (int i = 0; i < ENTRIES; i++)
            if (!found && line_valid[i] && line_key[i] == r.lookup_key)
            begin
                slot  = i;
                found = 1'b1;
            end

        if (found)
        begin
            res.hit = 1'b1;
            if (r.opcode == lkv_pkg::OP_PUT)
                line_value[slot] = r.write_value;
            else
                res.read_value = line_value[slot];
            make_most_recent(slot);
        end
        else if (r.opcode == lkv_pkg::OP_PUT)
        begin
            // full (or over-full after a capacity drop): recycle the tail entry
            if (line_count >= cap_eff)
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (!have && line_valid[i] && line_rank[i] + 1 == line_count)
                    begin
                        slot = i;
                        have = 1'b1;
                    end
                if (have)
                begin
                    res.evicted       = 1'b1;
                    res.evicted_key   = line_key[slot];
                    res.evicted_value = line_value[slot];
                    make_most_recent(slot);
                end
            end
            if (!have)
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (!have && !line_valid[i])
                    begin
                        slot = i;
                        have = 1'b1;
                    end
                if (have)
                begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (line_valid[i])
                            line_rank[i]++;
                    line_valid[slot] = 1'b1;
                    line_rank[slot]  = 0;
                    line_count++;
                end
            end
            if (have)
            begin
                line_key[slot]   = r.lookup_key;
                line_value[slot] = r.write_value;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic void queue_access(logic op, logic [lkv_pkg::KEY_W-1:0] key,
                                         logic [lkv_pkg::VAL_W-1:0] value);
        lkv_pkg::req_t r;
        r.opcode      = op;
        r.lookup_key  = key;
        r.write_value = value;
        pending_reqs.push_back(r);
    endfunction

    // Wait until nothing is queued, in flight or owed, then let the pipe settle.
    task automatic wait_quiet();
        while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Capacity write; only issued while the block is quiet.
    task automatic write_capacity(logic [lkv_pkg::CAP_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        capacity_reg = value;
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued items. A stalled item is held unchanged; the
    // shadow cache is updated at the edge where the transfer happens.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_rsps.push_back(lru_access(in_data));
            if (!in_valid || !in_stall)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_reqs.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every response transfer is checked against the oldest owed
    // response, field by field. Stall is redrawn each cycle.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : response_check
        lkv_pkg::rsp_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    report_mismatch("response with nothing outstanding");
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (out_data.hit !== want.hit)
                        report_mismatch($sformatf("hit got %b exp %b",
                                                  out_data.hit, want.hit));
                    if (out_data.read_value !== want.read_value)
                        report_mismatch($sformatf("read_value got %h exp %h",
                                                  out_data.read_value, want.read_value));
                    if (out_data.evicted !== want.evicted)
                        report_mismatch($sformatf("evicted got %b exp %b",
                                                  out_data.evicted, want.evicted));
                    if (out_data.evicted_key !== want.evicted_key)
                        report_mismatch($sformatf("evicted_key got %h exp %h",
                                                  out_data.evicted_key, want.evicted_key));
                    if (out_data.evicted_value !== want.evicted_value)
                        report_mismatch($sformatf("evicted_value got %h exp %h",
                                                  out_data.evicted_value,
                                                  want.evicted_value));
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: any transfer on any channel resets the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: directed corner cases, then random phases with varying
    // capacity and back-pressure. Each phase boundary drains the block,
    // so the sender sits idle until every owed response has arrived.
    // ------------------------------------------------------------------
    initial
    begin
        logic [lkv_pkg::CAP_W-1:0] phase_cap [NUM_PHASES];
        int          phase_send  [NUM_PHASES];
        int          phase_recv  [NUM_PHASES];
        int          phase_items [NUM_PHASES];
        int          cap_eff;
        int          pool_used;
        logic        op;
        logic [lkv_pkg::KEY_W-1:0] key;

        phase_cap   = '{5'd31, 5'd4, 5'd1, 5'd0, 5'd9, 5'd16};
        phase_send  = '{0, 78, 0, 15, 15, 0};
        phase_recv  = '{0, 0, 78, 15, 15, 0};
        phase_items = '{80, 70, 60, 50, 70, 70};

        for (int i = 0; i < ENTRIES; i++)
        begin
            line_key[i]   = '0;
            line_value[i] = '0;
            line_valid[i] = 1'b0;
            line_rank[i]  = 0;
        end
        line_count   = 0;
        capacity_reg = lkv_pkg::CAP_RESET;

        // key pool: includes both extremes, rest random
        pool_keys[0] = '0;
        pool_keys[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            pool_keys[i] = $urandom;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // basic hits and misses at reset capacity
        write_capacity(5'd16);
        @(negedge clk);
        queue_access(lkv_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);  // miss on empty cache
        queue_access(lkv_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_access(lkv_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_access(lkv_pkg::OP_PUT, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
        queue_access(lkv_pkg::OP_GET, 32'h0000_0000, 32'h1234_5678);
        queue_access(lkv_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_access(lkv_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0001);  // put that hits
        queue_access(lkv_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
        queue_access(lkv_pkg::OP_GET, 32'h1234_5678, 32'hFFFF_FFFF);  // get miss
        wait_quiet();

        // capacity lowered below the fill: each insert evicts one, fill stays
        write_capacity(5'd2);
        @(negedge clk);
        queue_access(lkv_pkg::OP_PUT, 32'h0000_0011, 32'h1111_1111);
        queue_access(lkv_pkg::OP_PUT, 32'h0000_0022, 32'h2222_2222);
        queue_access(lkv_pkg::OP_PUT, 32'h0000_0033, 32'h3333_3333);
        queue_access(lkv_pkg::OP_GET, 32'h5A5A_5A5A, 32'h0000_0000);  // evicted earlier
        wait_quiet();

        // zero capacity acts as one
        write_capacity(5'd0);
        @(negedge clk);
        queue_access(lkv_pkg::OP_PUT, 32'h0000_0044, 32'h4444_4444);
        queue_access(lkv_pkg::OP_GET, 32'h0000_0044, 32'h0000_0000);
        queue_access(lkv_pkg::OP_GET, 32'h0000_0011, 32'h0000_0000);
        wait_quiet();

        // capacity above the row size acts as the row size
        write_capacity(5'd31);
        @(negedge clk);
        queue_access(lkv_pkg::OP_PUT, 32'h0000_0055, 32'h8000_0000);
        queue_access(lkv_pkg::OP_PUT, 32'h0000_0055, 32'h7FFF_FFFF);
        queue_access(lkv_pkg::OP_GET, 32'h0000_0055, 32'h0000_0000);
        wait_quiet();

        // random phases: mostly keys from a pool a little larger than the
        // capacity, so hits and evictions both happen; some stray keys too
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_capacity(phase_cap[p]);
            cap_eff = (phase_cap[p] == 0) ? 1 : int'(phase_cap[p]);
            if (cap_eff > ENTRIES)
                cap_eff = ENTRIES;
            pool_used = cap_eff + 4;
            @(negedge clk);
            send_idle_pct  = phase_send[p];
            recv_stall_pct = phase_recv[p];
            for (int n = 0; n < phase_items[p]; n++)
            begin
                op = $urandom_range(1) ? lkv_pkg::OP_PUT : lkv_pkg::OP_GET;
                if ($urandom_range(99) < 88)
                    key = pool_keys[$urandom_range(pool_used - 1)];
                else
                    key = $urandom;
                queue_access(op, key, $urandom);
            end
            wait_quiet();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
